// ===== design/q4_q8_block_dot_product_unit_defines.svh =====
// Assertion macros for the block dot product unit
`ifndef Q4_Q8_BLOCK_DOT_PRODUCT_UNIT_DEFINES_SVH
`define Q4_Q8_BLOCK_DOT_PRODUCT_UNIT_DEFINES_SVH

// same-cycle implication
`define QDP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define QDP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/qdp_pkg.sv =====
`default_nettype none
package qdp_pkg;

    localparam int LANES    = 4;
    localparam int SUM_W    = 17;
    localparam int PART_W   = 13;
    localparam int MAN_W    = 50;
    localparam int EXP_W    = 11;
    localparam logic [31:0] QNAN   = 32'h7FC0_0000;
    localparam logic [31:0] FP_INF = 32'h7F80_0000;

    typedef enum logic [1:0] {
        FOP_CVT,
        FOP_MULH,
        FOP_ADD
    } fop_t;

    typedef struct packed {
        logic        start;
        fop_t        op;
        logic [31:0] a;
        logic [31:0] b;
    } fpu_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] res;
    } fpu_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CVT,
        ST_CVT_W,
        ST_MULW,
        ST_MULW_W,
        ST_MULA,
        ST_MULA_W,
        ST_ADD,
        ST_ADD_W,
        ST_EMIT
    } qdp_state_t;

endpackage
`default_nettype wire

// ===== design/qdp_lane.sv =====
`default_nettype none
module qdp_lane (
    input  wire logic [7:0]                        wbyte,
    input  wire logic [7:0]                        act_lo,
    input  wire logic [7:0]                        act_hi,
    output logic signed [qdp_pkg::PART_W-1:0]      part
);
    logic signed [3:0]  w_lo;
    logic signed [3:0]  w_hi;
    logic signed [11:0] p_lo;
    logic signed [11:0] p_hi;

    // nibble minus eight is the nibble with its top bit flipped
    assign w_lo = {~wbyte[3], wbyte[2:0]};
    assign w_hi = {~wbyte[7], wbyte[6:4]};
    assign p_lo = w_lo * $signed(act_lo);
    assign p_hi = w_hi * $signed(act_hi);
    assign part = qdp_pkg::PART_W'(p_lo) + qdp_pkg::PART_W'(p_hi);
endmodule
`default_nettype wire

// ===== design/qdp_merge.sv =====
`default_nettype none
module qdp_merge (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic signed [qdp_pkg::PART_W-1:0]     parts [qdp_pkg::LANES],
    input  wire logic                                  add_en,
    input  wire logic                                  clr,
    output logic [qdp_pkg::SUM_W-1:0]                  blk_sum
);
    logic signed [14:0]               item_sum;
    logic [qdp_pkg::SUM_W-1:0]        sum_reg;
    logic [qdp_pkg::SUM_W-1:0]        sum_next;

    assign item_sum = 15'(parts[0]) + 15'(parts[1]) + 15'(parts[2]) + 15'(parts[3]);

    always_comb begin
        sum_next = sum_reg;
        if (clr) begin
            sum_next = '0;
        end else if (add_en) begin
            sum_next = sum_reg + qdp_pkg::SUM_W'(item_sum);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
        end else begin
            sum_reg <= sum_next;
        end
    end

    assign blk_sum = sum_reg;
endmodule
`default_nettype wire

// ===== design/qdp_fpu.sv =====
`default_nettype none
module qdp_fpu (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire qdp_pkg::fpu_req_t req,
    output qdp_pkg::fpu_rsp_t      rsp
);
    localparam int MW = qdp_pkg::MAN_W;
    localparam int EW = qdp_pkg::EXP_W;

    logic              sa, sb, sh;
    logic [7:0]        ea8, eb8;
    logic [4:0]        eh5;
    logic [8:0]        ea, eb, eh;
    logic [23:0]       ma, mb, mh;
    logic              a_nan, a_inf, a_zero, b_nan, b_inf, h_nan, h_inf, h_zero;
    logic [47:0]       prod;
    logic [16:0]       ival, imag;
    logic              a_big;
    logic [8:0]        el, es;
    logic [23:0]       ml, ms;
    logic [8:0]        dsh;
    logic [MW-1:0]     ms_full, ms_shift, ms_al, add_man;

    logic              init_sign, init_spec;
    logic signed [EW-1:0] init_exp;
    logic [MW-1:0]     init_man;
    logic [31:0]       init_bits;

    logic              busy_reg, busy_next;
    logic              spec_reg, spec_next;
    logic              sign_reg, sign_next;
    logic signed [EW-1:0] exp_reg, exp_next;
    logic [MW-1:0]     man_reg, man_next;
    logic [31:0]       bits_reg, bits_next;

    logic              over, can_left, under, step, fin;
    logic              rnd;
    logic [24:0]       m25;
    logic [EW-1:0]     em1;
    logic [33:0]       total;

    always_comb begin
        sa  = req.a[31];
        ea8 = req.a[30:23];
        sb  = req.b[31];
        eb8 = req.b[30:23];
        sh  = req.b[15];
        eh5 = req.b[14:10];
        ea  = (ea8 == 8'd0) ? 9'd1 : {1'b0, ea8};
        eb  = (eb8 == 8'd0) ? 9'd1 : {1'b0, eb8};
        eh  = (eh5 == 5'd0) ? 9'd113 : 9'(eh5) + 9'd112;
        ma  = {ea8 != 8'd0, req.a[22:0]};
        mb  = {eb8 != 8'd0, req.b[22:0]};
        mh  = {eh5 != 5'd0, req.b[9:0], 13'd0};
        a_nan  = (ea8 == 8'hFF) && (req.a[22:0] != '0);
        a_inf  = (ea8 == 8'hFF) && (req.a[22:0] == '0);
        a_zero = (ea8 == 8'd0) && (req.a[22:0] == '0);
        b_nan  = (eb8 == 8'hFF) && (req.b[22:0] != '0);
        b_inf  = (eb8 == 8'hFF) && (req.b[22:0] == '0);
        h_nan  = (eh5 == 5'h1F) && (req.b[9:0] != '0);
        h_inf  = (eh5 == 5'h1F) && (req.b[9:0] == '0);
        h_zero = (eh5 == 5'd0) && (req.b[9:0] == '0);
        prod = 48'(ma) * 48'(mh);

        ival = req.a[16:0];
        imag = ival[16] ? 17'(-ival) : ival;

        a_big    = {ea, ma} >= {eb, mb};
        el       = a_big ? ea : eb;
        es       = a_big ? eb : ea;
        ml       = a_big ? ma : mb;
        ms       = a_big ? mb : ma;
        dsh      = el - es;
        ms_full  = {2'b00, ms, 24'd0};
        ms_shift = ms_full >> dsh;
        ms_al    = ms_shift | MW'(ms_full != (ms_shift << dsh));
        add_man  = (sa == sb) ? ({2'b00, ml, 24'd0} + ms_al) : ({2'b00, ml, 24'd0} - ms_al);

        init_sign = 1'b0;
        init_spec = 1'b0;
        init_exp  = '0;
        init_man  = '0;
        init_bits = '0;
        unique case (req.op)
            qdp_pkg::FOP_CVT: begin
                init_sign = ival[16];
                init_exp  = EW'(174);
                init_man  = MW'(imag);
            end
            qdp_pkg::FOP_MULH: begin
                init_sign = sa ^ sh;
                init_exp  = EW'(ea) + EW'(eh) - EW'(127);
                init_man  = {1'b0, prod, 1'b0};
                if (a_nan || h_nan || (a_inf && h_zero) || (h_inf && a_zero)) begin
                    init_spec = 1'b1;
                    init_bits = qdp_pkg::QNAN;
                end else if (a_inf || h_inf) begin
                    init_spec = 1'b1;
                    init_bits = {sa ^ sh, 31'd0} | qdp_pkg::FP_INF;
                end else if (a_zero || h_zero) begin
                    init_spec = 1'b1;
                    init_bits = {sa ^ sh, 31'd0};
                end
            end
            qdp_pkg::FOP_ADD: begin
                init_sign = (add_man == '0) ? (sa & sb) : (a_big ? sa : sb);
                init_exp  = EW'(el);
                init_man  = add_man;
                if (a_nan || b_nan || (a_inf && b_inf && (sa != sb))) begin
                    init_spec = 1'b1;
                    init_bits = qdp_pkg::QNAN;
                end else if (a_inf) begin
                    init_spec = 1'b1;
                    init_bits = req.a;
                end else if (b_inf) begin
                    init_spec = 1'b1;
                    init_bits = req.b;
                end
            end
            default: begin
                init_spec = 1'b1;
                init_bits = qdp_pkg::QNAN;
            end
        endcase
    end

    always_comb begin
        over     = |man_reg[MW-1:MW-2];
        can_left = (man_reg != '0) && !man_reg[47] && (exp_reg > EW'(1));
        under    = (man_reg != '0) && (exp_reg < EW'(1));
        step     = !spec_reg && (over || can_left || under);
        fin      = busy_reg && !step;

        rnd   = man_reg[23] & ((|man_reg[22:0]) | man_reg[24]);
        m25   = 25'(man_reg[47:24]) + 25'(rnd);
        em1   = EW'(exp_reg - EW'(1));
        total = {em1, 23'd0} + 34'(m25);

        rsp.done = fin;
        if (spec_reg) begin
            rsp.res = bits_reg;
        end else if (man_reg == '0) begin
            rsp.res = {sign_reg, 31'd0};
        end else if (total[33:23] >= 11'd255) begin
            rsp.res = {sign_reg, 31'd0} | qdp_pkg::FP_INF;
        end else begin
            rsp.res = {sign_reg, total[30:0]};
        end

        busy_next = busy_reg;
        spec_next = spec_reg;
        sign_next = sign_reg;
        exp_next  = exp_reg;
        man_next  = man_reg;
        bits_next = bits_reg;
        if (req.start) begin
            busy_next = 1'b1;
            spec_next = init_spec;
            sign_next = init_sign;
            exp_next  = init_exp;
            man_next  = init_man;
            bits_next = init_bits;
        end else if (fin) begin
            busy_next = 1'b0;
        end else if (busy_reg) begin
            priority if (over || under) begin
                man_next = {1'b0, man_reg[MW-1:2], man_reg[1] | man_reg[0]};
                exp_next = exp_reg + EW'(1);
            end else begin
                man_next = {man_reg[MW-2:0], 1'b0};
                exp_next = exp_reg - EW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        spec_reg <= spec_next;
        sign_reg <= sign_next;
        exp_reg  <= exp_next;
        man_reg  <= man_next;
        bits_reg <= bits_next;
    end
endmodule
`default_nettype wire

// ===== design/q4_q8_block_dot_product_unit.sv =====
// Quantised 4-bit by 8-bit block dot product. Each input beat carries four weight bytes and
// eight int8 activations; four lanes form the eight products and a merge stage adds them into
// a 17-bit block sum, so beats that do not close a block are taken one per cycle. A beat that
// closes a block (tuser or tlast) starts a sequence on one shared fp32 unit: convert the block
// sum, multiply by the weight scale, multiply by the activation scale, add to the row sum. Each
// of those four steps is a start state and a wait state in which the unit normalises by shifts,
// and a closing beat holds the input until all four are through; the conversion needs no shifts
// for a zero block sum. On tlast the row sum passes through ST_EMIT to the output register,
// once any unread result there has been taken, which lets the next row start while it waits.
`default_nettype none
`include "q4_q8_block_dot_product_unit_defines.svh"
module q4_q8_block_dot_product_unit (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [127:0] s_tdata,  // weight_bytes, act_low, act_high, weight_scale, act_scale
    input  wire logic         s_tuser,  // block_end
    input  wire logic         s_tlast,  // row_end
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [31:0]       m_tdata   // dot_value
);
    qdp_pkg::qdp_state_t state_reg, state_next;
    logic signed [qdp_pkg::PART_W-1:0] parts [qdp_pkg::LANES];
    logic [qdp_pkg::SUM_W-1:0] blk_sum;
    logic add_en, clr, accept, close;
    qdp_pkg::fpu_req_t fpu_req;
    qdp_pkg::fpu_rsp_t fpu_rsp;
    logic [15:0] ws_reg, ws_next, as_reg, as_next;
    logic        rend_reg, rend_next;
    logic [31:0] t_reg, t_next, row_reg, row_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [31:0] m_tdata_reg, m_tdata_next;
    logic [31:0] row_canon;
    logic        fpu_wait;

    for (genvar i = 0; i < qdp_pkg::LANES; i++) begin : g_lane
        qdp_lane u_lane (
            .wbyte  (s_tdata[8*i +: 8]),
            .act_lo (s_tdata[32 + 8*i +: 8]),
            .act_hi (s_tdata[64 + 8*i +: 8]),
            .part   (parts[i])
        );
    end

    qdp_merge u_merge (
        .aclk    (aclk),
        .aresetn (aresetn),
        .parts   (parts),
        .add_en  (add_en),
        .clr     (clr),
        .blk_sum (blk_sum)
    );

    qdp_fpu u_fpu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (fpu_req),
        .rsp     (fpu_rsp)
    );

    assign accept = s_tvalid && s_tready;
    assign close  = s_tuser || s_tlast;
    assign row_canon = ((row_reg[30:23] == 8'hFF) && (row_reg[22:0] != '0)) ?
                       qdp_pkg::QNAN : row_reg;
    assign fpu_wait = (state_reg == qdp_pkg::ST_CVT_W) || (state_reg == qdp_pkg::ST_MULW_W) ||
                      (state_reg == qdp_pkg::ST_MULA_W) || (state_reg == qdp_pkg::ST_ADD_W);

    always_comb begin
        state_next    = state_reg;
        s_tready      = 1'b0;
        add_en        = 1'b0;
        clr           = 1'b0;
        fpu_req.start = 1'b0;
        fpu_req.op    = qdp_pkg::FOP_CVT;
        fpu_req.a     = {15'd0, blk_sum};
        fpu_req.b     = '0;
        ws_next       = ws_reg;
        as_next       = as_reg;
        rend_next     = rend_reg;
        t_next        = t_reg;
        row_next      = row_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        unique case (state_reg)
            qdp_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (accept) begin
                    add_en = 1'b1;
                    if (close) begin
                        ws_next    = s_tdata[111:96];
                        as_next    = s_tdata[127:112];
                        rend_next  = s_tlast;
                        state_next = qdp_pkg::ST_CVT;
                    end
                end
            end
            qdp_pkg::ST_CVT: begin
                fpu_req.start = 1'b1;
                clr           = 1'b1;
                state_next    = qdp_pkg::ST_CVT_W;
            end
            qdp_pkg::ST_CVT_W: begin
                if (fpu_rsp.done) begin
                    t_next     = fpu_rsp.res;
                    state_next = qdp_pkg::ST_MULW;
                end
            end
            qdp_pkg::ST_MULW: begin
                fpu_req.start = 1'b1;
                fpu_req.op    = qdp_pkg::FOP_MULH;
                fpu_req.a     = t_reg;
                fpu_req.b     = {16'd0, ws_reg};
                state_next    = qdp_pkg::ST_MULW_W;
            end
            qdp_pkg::ST_MULW_W: begin
                if (fpu_rsp.done) begin
                    t_next     = fpu_rsp.res;
                    state_next = qdp_pkg::ST_MULA;
                end
            end
            qdp_pkg::ST_MULA: begin
                fpu_req.start = 1'b1;
                fpu_req.op    = qdp_pkg::FOP_MULH;
                fpu_req.a     = t_reg;
                fpu_req.b     = {16'd0, as_reg};
                state_next    = qdp_pkg::ST_MULA_W;
            end
            qdp_pkg::ST_MULA_W: begin
                if (fpu_rsp.done) begin
                    t_next     = fpu_rsp.res;
                    state_next = qdp_pkg::ST_ADD;
                end
            end
            qdp_pkg::ST_ADD: begin
                fpu_req.start = 1'b1;
                fpu_req.op    = qdp_pkg::FOP_ADD;
                fpu_req.a     = row_reg;
                fpu_req.b     = t_reg;
                state_next    = qdp_pkg::ST_ADD_W;
            end
            qdp_pkg::ST_ADD_W: begin
                if (fpu_rsp.done) begin
                    row_next   = fpu_rsp.res;
                    state_next = rend_reg ? qdp_pkg::ST_EMIT : qdp_pkg::ST_IDLE;
                end
            end
            qdp_pkg::ST_EMIT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = row_canon;
                    row_next      = '0;
                    state_next    = qdp_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = qdp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= qdp_pkg::ST_IDLE;
            row_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            row_reg      <= row_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        ws_reg      <= ws_next;
        as_reg      <= as_next;
        rend_reg    <= rend_next;
        t_reg       <= t_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `QDP_ASSERT_NEXT(a_close_starts_cvt, accept && close, state_reg == qdp_pkg::ST_CVT, "no cvt")
    `QDP_ASSERT_NEXT(a_cvt_clears_sum, state_reg == qdp_pkg::ST_CVT, blk_sum == '0, "sum kept")
    `QDP_ASSERT_NOW(a_done_when_waiting, fpu_rsp.done, fpu_wait, "fp unit done outside wait")
endmodule
`default_nettype wire
